/* hw/rtl/trtb_pkg.sv */
// Shared types, constants and register indexes of the triangle ramp texture blend unit.
package trtb_pkg;

	localparam int TEX_WIDTH  = 256;
	localparam int TEX_HEIGHT = 256;

	localparam int LE_SHIFT   = 16 - $clog2(TEX_HEIGHT);
	localparam int LB_SHIFT   = 32 - $clog2(TEX_HEIGHT);
	localparam int EDGE_SHIFT = 17 - $clog2(TEX_WIDTH);

	localparam int CH_W       = 17;
	localparam int CRD_W      = 8;
	localparam int GEO_W      = 18;
	localparam int COLOR_W    = 51;
	localparam int CFG_DATA_W = 51;
	localparam int CFG_IDX_W  = 3;

	localparam int DIV_STEPS = 19;
	localparam int DVD_W     = 37;
	localparam int DEN_W     = 20;
	localparam int COL_W     = 20;
	localparam int LEE_W     = 9;

	localparam logic [CH_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [CH_W-1:0] SAT17   = 17'h1FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_APEX_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_OFFSET_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_FRAC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDGET_COLOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ALPHA   = 3'd6;

	typedef struct packed {
		logic [CRD_W-1:0] row;
		logic [CRD_W-1:0] column;
		logic [CH_W-1:0]  in_red;
		logic [CH_W-1:0]  in_green;
		logic [CH_W-1:0]  in_blue;
		logic [CH_W-1:0]  in_alpha;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
		logic            covered;
	} out_item_t;

	typedef struct packed {
		logic                 cover_row;
		logic [2:0]           neg;
		logic [DIV_STEPS-1:0] mag_lo;
		logic [DIV_STEPS-1:0] mag_mid;
		logic [DIV_STEPS-1:0] mag_hi;
		logic [LEE_W-1:0]     lee;
	} geom_t;

endpackage

/* hw/rtl/trtb_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module trtb_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [trtb_pkg::DVD_W-1:0]        dividend,
	input  logic [trtb_pkg::DEN_W-1:0]        divisor,
	output logic [trtb_pkg::DIV_STEPS-1:0]    quotient
);

	localparam int STEPS = trtb_pkg::DIV_STEPS;
	localparam int REM_W = trtb_pkg::DEN_W;

	logic [REM_W-1:0] rem_s [1:STEPS];
	logic [STEPS-1:0] low_s [1:STEPS];
	logic [REM_W-1:0] den_s [1:STEPS-1];

	logic [REM_W-1:0] cur_rem [0:STEPS-1];
	logic [STEPS-1:0] cur_low [0:STEPS-1];
	logic [REM_W-1:0] cur_den [0:STEPS-1];
	logic [REM_W:0]   trial   [0:STEPS-1];
	logic             ge      [0:STEPS-1];
	logic [REM_W-1:0] nxt_rem [0:STEPS-1];
	logic [STEPS-1:0] nxt_low [0:STEPS-1];

	always_comb begin
		cur_rem[0] = REM_W'(dividend[trtb_pkg::DVD_W-1:STEPS]);
		cur_low[0] = dividend[STEPS-1:0];
		cur_den[0] = divisor;
		for (int k = 1; k < STEPS; k++) begin
			cur_rem[k] = rem_s[k];
			cur_low[k] = low_s[k];
			cur_den[k] = den_s[k];
		end
		for (int k = 0; k < STEPS; k++) begin
			trial[k] = {cur_rem[k], cur_low[k][STEPS-1]};
			ge[k] = trial[k] >= {1'b0, cur_den[k]};
			nxt_rem[k] = ge[k] ? REM_W'(trial[k] - {1'b0, cur_den[k]}) : trial[k][REM_W-1:0];
			nxt_low[k] = {cur_low[k][STEPS-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k+1] <= nxt_rem[k];
				low_s[k+1] <= nxt_low[k];
			end
			den_s[1] <= divisor;
			for (int k = 1; k < STEPS-1; k++) begin
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quotient = low_s[STEPS];

endmodule

/* hw/rtl/trtb_geom.sv */
// Row coverage test and edge column numerators, two register stages.
module trtb_geom (
	input  logic                              clk,
	input  logic                              en,
	input  logic [trtb_pkg::CRD_W-1:0]        row,
	input  logic signed [trtb_pkg::GEO_W-1:0] apex_x,
	input  logic signed [trtb_pkg::GEO_W-1:0] top_offset_x,
	input  logic signed [trtb_pkg::GEO_W-1:0] top_height,
	input  logic signed [trtb_pkg::GEO_W-1:0] top_width,
	input  logic signed [trtb_pkg::GEO_W-1:0] bottom_fraction,
	output trtb_pkg::geom_t                   geom
);

	logic [18:0]        ty_mag;
	logic [10:0]        le_mag;
	logic signed [10:0] le_c;
	logic               lez;
	logic [7:0]         ie;
	logic [8:0]         lee_c;
	logic signed [19:0] toff2;
	logic signed [19:0] tw20;
	logic signed [19:0] q_lo, q_mid, q_hi;

	logic signed [28:0] pq_lo_s1, pq_mid_s1, pq_hi_s1;
	logic signed [27:0] pa_s1;
	logic signed [35:0] pbt_s1;
	logic signed [10:0] le_s1;
	logic [8:0]         lee_s1;
	logic [7:0]         row_s1;

	logic [35:0]        pbt_mag;
	logic [11:0]        lbm;
	logic signed [12:0] lb;
	logic signed [29:0] pa2;
	logic signed [29:0] n_lo, n_mid, n_hi;
	logic [29:0]        m_lo, m_mid, m_hi;

	always_comb begin
		ty_mag = top_height[17] ? 19'(-$signed({top_height[17], top_height}))
			: {1'b0, top_height};
		le_mag = 11'(ty_mag >> trtb_pkg::LE_SHIFT);
		le_c = top_height[17] ? -$signed(le_mag) : $signed(le_mag);
		lez = (le_c == 11'sd0);
		ie = lez ? 8'd0 : row;
		lee_c = lez ? 9'd1 : le_c[8:0];
		toff2 = $signed({top_offset_x[17], top_offset_x, 1'b0});
		tw20 = $signed({{2{top_width[17]}}, top_width});
		q_lo = toff2 - tw20;
		q_mid = toff2;
		q_hi = toff2 + tw20;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pq_lo_s1 <= $signed({1'b0, ie}) * q_lo;
			pq_mid_s1 <= $signed({1'b0, ie}) * q_mid;
			pq_hi_s1 <= $signed({1'b0, ie}) * q_hi;
			pa_s1 <= $signed({1'b0, lee_c}) * apex_x;
			pbt_s1 <= bottom_fraction * top_height;
			le_s1 <= le_c;
			lee_s1 <= lee_c;
			row_s1 <= row;
		end
	end

	always_comb begin
		pbt_mag = pbt_s1[35] ? 36'(-pbt_s1) : pbt_s1;
		lbm = 12'(pbt_mag >> trtb_pkg::LB_SHIFT);
		lb = pbt_s1[35] ? -$signed({1'b0, lbm}) : $signed({1'b0, lbm});
		pa2 = $signed({pa_s1[27], pa_s1, 1'b0});
		n_lo = $signed({pq_lo_s1[28], pq_lo_s1}) + pa2;
		n_mid = $signed({pq_mid_s1[28], pq_mid_s1}) + pa2;
		n_hi = $signed({pq_hi_s1[28], pq_hi_s1}) + pa2;
		m_lo = n_lo[29] ? 30'(-n_lo) : n_lo;
		m_mid = n_mid[29] ? 30'(-n_mid) : n_mid;
		m_hi = n_hi[29] ? 30'(-n_hi) : n_hi;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom.cover_row <= ($signed({5'b0, row_s1}) >= lb)
				&& ($signed({3'b0, row_s1}) <= le_s1);
			geom.neg <= {n_hi[29], n_mid[29], n_lo[29]};
			geom.mag_lo <= m_lo[trtb_pkg::EDGE_SHIFT+trtb_pkg::DIV_STEPS-1:trtb_pkg::EDGE_SHIFT];
			geom.mag_mid <= m_mid[trtb_pkg::EDGE_SHIFT+trtb_pkg::DIV_STEPS-1:trtb_pkg::EDGE_SHIFT];
			geom.mag_hi <= m_hi[trtb_pkg::EDGE_SHIFT+trtb_pkg::DIV_STEPS-1:trtb_pkg::EDGE_SHIFT];
			geom.lee <= lee_s1;
		end
	end

endmodule

/* hw/rtl/trtb_blend.sv */
// Blend of the texel with the widget color and alpha, two register stages.
module trtb_blend (
	input  logic                                clk,
	input  logic                                en,
	input  trtb_pkg::in_item_t                  item,
	input  logic                                cov,
	input  logic [trtb_pkg::CH_W-1:0]           alpha,
	input  logic [trtb_pkg::COLOR_W-1:0]        widget_color,
	output trtb_pkg::out_item_t                 result
);

	logic [trtb_pkg::CH_W-1:0] keep;
	logic [33:0]               pr_s1, pg_s1, pb_s1, pa_s1;
	logic [trtb_pkg::CH_W-1:0] a_s1;
	logic                      cov_s1;
	trtb_pkg::in_item_t        item_s1;

	function automatic logic [16:0] sat_add(input logic [33:0] prod, input logic [16:0] add);
		logic [17:0] sum;
		sum = {1'b0, prod[32:16]} + {1'b0, add};
		return sum[17] ? trtb_pkg::SAT17 : sum[16:0];
	endfunction

	assign keep = trtb_pkg::ONE_Q16 - alpha;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1 <= item.in_red * keep;
			pg_s1 <= item.in_green * keep;
			pb_s1 <= item.in_blue * keep;
			pa_s1 <= item.in_alpha * keep;
			a_s1 <= alpha;
			cov_s1 <= cov;
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cov_s1) begin
				result.out_red <= sat_add(pr_s1, widget_color[50:34]);
				result.out_green <= sat_add(pg_s1, widget_color[33:17]);
				result.out_blue <= sat_add(pb_s1, widget_color[16:0]);
				result.out_alpha <= sat_add(pa_s1, a_s1);
			end else begin
				result.out_red <= item_s1.in_red;
				result.out_green <= item_s1.in_green;
				result.out_blue <= item_s1.in_blue;
				result.out_alpha <= item_s1.in_alpha;
			end
			result.covered <= cov_s1;
		end
	end

endmodule

/* hw/rtl/triangle_ramp_texture_blend_unit.sv */
// Top level of the triangle ramp texture blend unit.
// Blends a triangular transfer-function ramp into a stream of RGBA texels.
// The src channel takes one texel item (row, column, old RGBA) on each edge
// where src_valid is high and src_stall is low. The dst channel presents the
// blended texel and its covered flag; it is taken where dst_valid is high and
// dst_stall is low. Every input item yields exactly one output item, in order.
// The pipeline holds 45 register stages and accepts one item per cycle while
// dst_stall does not hold it. The depth is set by two 19-stage divider ranks
// in series: three parallel edge column dividers and one alpha ramp divider.
// When dst_stall is high while an item waits at the output, the whole pipeline
// holds and src_stall rises in the same cycle; nothing is lost or repeated.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and must only change while no item is in flight. Reset empties the pipeline
// and loads the default widget geometry, color and peak alpha.
module triangle_ramp_texture_blend_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 src_valid,
	output logic                                 src_stall,
	input  trtb_pkg::in_item_t                   src_item,
	output logic                                 dst_valid,
	input  logic                                 dst_stall,
	output trtb_pkg::out_item_t                  dst_item,
	input  logic                                 cfg_we,
	input  logic [trtb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [trtb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int ST_GEOM  = 2;
	localparam int ST_EDGE  = ST_GEOM + trtb_pkg::DIV_STEPS;
	localparam int ST_POS   = ST_EDGE + 1;
	localparam int ST_SIDE  = ST_POS + 1;
	localparam int ST_PROD  = ST_SIDE + 1;
	localparam int ST_ALPHA = ST_PROD + trtb_pkg::DIV_STEPS;
	localparam int ST_OUT   = ST_ALPHA + 2;

	localparam int CW = trtb_pkg::COL_W;

	logic signed [trtb_pkg::GEO_W-1:0] apex_x_q, top_offset_x_q, top_height_q;
	logic signed [trtb_pkg::GEO_W-1:0] top_width_q, bottom_fraction_q;
	logic [trtb_pkg::COLOR_W-1:0]      widget_color_q;
	logic [trtb_pkg::CH_W-1:0]         peak_alpha_q;

	logic adv;
	logic vld_s [1:ST_OUT];
	trtb_pkg::in_item_t item_s [1:ST_ALPHA];
	logic cvr_s [ST_GEOM+1:ST_EDGE];
	logic [2:0] neg_s [ST_GEOM+1:ST_EDGE];
	logic cov_s [ST_PROD+1:ST_ALPHA];

	trtb_pkg::geom_t geom;
	logic [trtb_pkg::DIV_STEPS-1:0] q_lo, q_mid, q_hi, q_alpha;

	logic signed [CW-1:0] rb_s22, rm_s22, re_s22;
	logic                 cvr_s22;
	logic signed [CW-1:0] j_c;
	logic                 rise_c, fall_c;
	logic [CW:0]          nd_c, dn_c;
	logic                 cov_s23;
	logic [trtb_pkg::DEN_W-1:0] nd_s23, dn_s23;
	logic [trtb_pkg::CH_W-1:0]  peak_c;
	logic [trtb_pkg::DVD_W-1:0] dvd_s24;
	logic [trtb_pkg::DEN_W-1:0] dn_s24;
	logic                       cov_s24;

	assign adv = !(vld_s[ST_OUT] && dst_stall);
	assign src_stall = !adv;
	assign dst_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_x_q <= 18'sd32768;
			top_offset_x_q <= 18'sd9830;
			top_height_q <= 18'sd32768;
			top_width_q <= 18'sd16384;
			bottom_fraction_q <= 18'sd32768;
			widget_color_q <= 51'd562954248454144;
			peak_alpha_q <= 17'd45875;
		end else if (cfg_we) begin
			case (cfg_index)
				trtb_pkg::CFG_APEX_X: apex_x_q <= $signed(cfg_data[17:0]);
				trtb_pkg::CFG_TOP_OFFSET_X: top_offset_x_q <= $signed(cfg_data[17:0]);
				trtb_pkg::CFG_TOP_HEIGHT: top_height_q <= $signed(cfg_data[17:0]);
				trtb_pkg::CFG_TOP_WIDTH: top_width_q <= $signed(cfg_data[17:0]);
				trtb_pkg::CFG_BOTTOM_FRAC: bottom_fraction_q <= $signed(cfg_data[17:0]);
				trtb_pkg::CFG_WIDGET_COLOR: widget_color_q <= cfg_data;
				trtb_pkg::CFG_PEAK_ALPHA: peak_alpha_q <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_OUT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= src_valid;
			for (int k = 2; k <= ST_OUT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s[1] <= src_item;
			for (int k = 2; k <= ST_ALPHA; k++) begin
				item_s[k] <= item_s[k-1];
			end
			cvr_s[ST_GEOM+1] <= geom.cover_row;
			neg_s[ST_GEOM+1] <= geom.neg;
			for (int k = ST_GEOM+2; k <= ST_EDGE; k++) begin
				cvr_s[k] <= cvr_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			cov_s[ST_PROD+1] <= cov_s24;
			for (int k = ST_PROD+2; k <= ST_ALPHA; k++) begin
				cov_s[k] <= cov_s[k-1];
			end
		end
	end

	trtb_geom u_geom (
		.clk             (clk),
		.en              (adv),
		.row             (src_item.row),
		.apex_x          (apex_x_q),
		.top_offset_x    (top_offset_x_q),
		.top_height      (top_height_q),
		.top_width       (top_width_q),
		.bottom_fraction (bottom_fraction_q),
		.geom            (geom)
	);

	trtb_div u_div_lo (
		.clk      (clk),
		.en       (adv),
		.dividend (trtb_pkg::DVD_W'(geom.mag_lo)),
		.divisor  (trtb_pkg::DEN_W'(geom.lee)),
		.quotient (q_lo)
	);

	trtb_div u_div_mid (
		.clk      (clk),
		.en       (adv),
		.dividend (trtb_pkg::DVD_W'(geom.mag_mid)),
		.divisor  (trtb_pkg::DEN_W'(geom.lee)),
		.quotient (q_mid)
	);

	trtb_div u_div_hi (
		.clk      (clk),
		.en       (adv),
		.dividend (trtb_pkg::DVD_W'(geom.mag_hi)),
		.divisor  (trtb_pkg::DEN_W'(geom.lee)),
		.quotient (q_hi)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			rb_s22 <= neg_s[ST_EDGE][0] ? -$signed({1'b0, q_lo}) : $signed({1'b0, q_lo});
			rm_s22 <= neg_s[ST_EDGE][1] ? -$signed({1'b0, q_mid}) : $signed({1'b0, q_mid});
			re_s22 <= neg_s[ST_EDGE][2] ? -$signed({1'b0, q_hi}) : $signed({1'b0, q_hi});
			cvr_s22 <= cvr_s[ST_EDGE];
		end
	end

	always_comb begin
		j_c = $signed({{(CW-trtb_pkg::CRD_W){1'b0}}, item_s[ST_POS].column});
		rise_c = (j_c >= rb_s22) && (j_c < rm_s22);
		fall_c = (j_c >= rm_s22) && (j_c < re_s22);
		nd_c = rise_c ? ({j_c[CW-1], j_c} - {rb_s22[CW-1], rb_s22})
			: ({re_s22[CW-1], re_s22} - {j_c[CW-1], j_c});
		dn_c = rise_c ? ({rm_s22[CW-1], rm_s22} - {rb_s22[CW-1], rb_s22})
			: ({re_s22[CW-1], re_s22} - {rm_s22[CW-1], rm_s22});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s23 <= cvr_s22 && (rise_c || fall_c);
			nd_s23 <= nd_c[trtb_pkg::DEN_W-1:0];
			dn_s23 <= dn_c[trtb_pkg::DEN_W-1:0];
		end
	end

	assign peak_c = (peak_alpha_q > trtb_pkg::ONE_Q16) ? trtb_pkg::ONE_Q16 : peak_alpha_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s24 <= peak_c * nd_s23;
			dn_s24 <= dn_s23;
			cov_s24 <= cov_s23;
		end
	end

	trtb_div u_div_alpha (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_s24),
		.divisor  (dn_s24),
		.quotient (q_alpha)
	);

	trtb_blend u_blend (
		.clk          (clk),
		.en           (adv),
		.item         (item_s[ST_ALPHA]),
		.cov          (cov_s[ST_ALPHA]),
		.alpha        (q_alpha[trtb_pkg::CH_W-1:0]),
		.widget_color (widget_color_q),
		.result       (dst_item)
	);

endmodule

/* tb/trtb_blend_checker.sv */
// Checker that predicts and compares every blended texel of the blend unit.
`timescale 1ns / 1ps
module trtb_blend_checker
	import trtb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	input  logic                  src_stall,
	input  in_item_t              src_item,
	input  logic                  dst_valid,
	input  logic                  dst_stall,
	input  out_item_t             dst_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    texels_pending
);
	logic signed [GEO_W-1:0] apex_x, top_off, top_h, top_w, bot_frac;
	logic [COLOR_W-1:0]      widget_rgb;
	logic [CH_W-1:0]         peak_reg;
	out_item_t               blended_q[$];

	function automatic longint edge_column(longint ie, longint lee, longint q2, longint apex);
		longint num, den;
		num = longint'(TEX_WIDTH) * (ie * q2 + 2 * lee * apex);
		den = 2 * lee * 65536;
		return num / den;
	endfunction

	function automatic out_item_t blend_texel(in_item_t t);
		out_item_t r;
		longint lb, le, ie, lee, rb, rm, re, i, j;
		longint unsigned a, keep, peak, v;
		logic [CH_W-1:0] cc[3];
		logic [CH_W-1:0] ch[4];
		logic cov;
		cov = 1'b0;
		a = 0;
		peak = peak_reg;
		if (peak > 65536) peak = 65536;
		cc[0] = widget_rgb[50:34];
		cc[1] = widget_rgb[33:17];
		cc[2] = widget_rgb[16:0];
		ch[0] = t.in_red;
		ch[1] = t.in_green;
		ch[2] = t.in_blue;
		ch[3] = t.in_alpha;
		i = t.row;
		j = t.column;
		lb = (longint'(bot_frac) * longint'(top_h) * TEX_HEIGHT) / (64'sd1 << 32);
		le = (longint'(top_h) * TEX_HEIGHT) / 65536;
		if (i >= lb && i <= le) begin
			ie = (le == 0) ? 0 : i;
			lee = (le == 0) ? 1 : le;
			rb = edge_column(ie, lee, 2 * longint'(top_off) - longint'(top_w), apex_x);
			rm = edge_column(ie, lee, 2 * longint'(top_off), apex_x);
			re = edge_column(ie, lee, 2 * longint'(top_off) + longint'(top_w), apex_x);
			if (j >= rb && j < rm) begin
				cov = 1'b1;
				a = (peak * longint'(j - rb)) / longint'(rm - rb);
			end else if (j >= rm && j < re) begin
				cov = 1'b1;
				a = (peak * longint'(re - j)) / longint'(re - rm);
			end
		end
		if (cov) begin
			keep = 65536 - a;
			for (int k = 0; k < 4; k++) begin
				v = ((longint'(ch[k]) * keep) >> 16) + ((k == 3) ? a : longint'(cc[k]));
				if (v > 131071) v = 131071;
				ch[k] = v[CH_W-1:0];
			end
		end
		r.out_red = ch[0];
		r.out_green = ch[1];
		r.out_blue = ch[2];
		r.out_alpha = ch[3];
		r.covered = cov;
		return r;
	endfunction

	assign texels_pending = blended_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			apex_x <= 18'sd32768;
			top_off <= 18'sd9830;
			top_h <= 18'sd32768;
			top_w <= 18'sd16384;
			bot_frac <= 18'sd32768;
			widget_rgb <= 51'd562954248454144;
			peak_reg <= 17'd45875;
			fail_count <= 0;
			blended_q.delete();
		end else begin
			if (src_valid && !src_stall)
				blended_q.push_back(blend_texel(src_item));
			if (dst_valid && !dst_stall) begin
				if (blended_q.size() == 0) begin
					$display("%0t: unexpected item %h", $time, dst_item);
					fail_count <= fail_count + 1;
				end else begin
					want = blended_q.pop_front();
					if (want !== dst_item) begin
						$display("%0t: mismatch expected r=%h g=%h b=%h a=%h c=%b actual r=%h g=%h b=%h a=%h c=%b",
							$time, want.out_red, want.out_green, want.out_blue, want.out_alpha,
							want.covered, dst_item.out_red, dst_item.out_green,
							dst_item.out_blue, dst_item.out_alpha, dst_item.covered);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_APEX_X: begin
						apex_x <= cfg_data[GEO_W-1:0];
					end
					CFG_TOP_OFFSET_X: begin
						top_off <= cfg_data[GEO_W-1:0];
					end
					CFG_TOP_HEIGHT: begin
						top_h <= cfg_data[GEO_W-1:0];
					end
					CFG_TOP_WIDTH: begin
						top_w <= cfg_data[GEO_W-1:0];
					end
					CFG_BOTTOM_FRAC: begin
						bot_frac <= cfg_data[GEO_W-1:0];
					end
					CFG_WIDGET_COLOR: begin
						widget_rgb <= cfg_data[COLOR_W-1:0];
					end
					CFG_PEAK_ALPHA: begin
						peak_reg <= cfg_data[CH_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule

/* tb/triangle_ramp_texture_blend_unit_tb.sv */
// Stimulus, clocking and verdict for the triangle ramp texture blend unit.
`timescale 1ns / 1ps
module triangle_ramp_texture_blend_unit_tb;
	import trtb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_stall;
	in_item_t              src_item = '0;
	logic                  dst_valid;
	logic                  dst_stall = 1'b0;
	out_item_t             dst_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_APEX_X;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    texels_pending;
	int                    src_idle_pct = 0;
	int                    dst_stall_pct = 0;
	int                    quiet_cycles = 0;

	always #6 clk = ~clk;

	triangle_ramp_texture_blend_unit u_dut (.*);

	trtb_blend_checker u_checker (.*);

	always @(negedge clk)
		dst_stall <= ($urandom_range(99) < dst_stall_pct);

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_texel(in_item_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= t;
		do @(posedge clk); while (src_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		@(negedge clk);
		while (texels_pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic in_item_t rand_texel();
		in_item_t t;
		t.row = CRD_W'($urandom);
		t.column = CRD_W'($urandom);
		t.in_red = CH_W'($urandom);
		t.in_green = CH_W'($urandom);
		t.in_blue = CH_W'($urandom);
		t.in_alpha = CH_W'($urandom);
		return t;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_color();
		return CFG_DATA_W'({$urandom, $urandom});
	endfunction

	initial begin
		in_item_t t;
		int mode;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int d = 0; d < 20; d++) begin
			t = rand_texel();
			t.row = (d % 4 == 0) ? 8'd0 : (d % 4 == 1) ? 8'd255 : CRD_W'(64 + d);
			t.column = (d % 3 == 0) ? 8'd0 : (d % 3 == 1) ? 8'd255 : CRD_W'(8 * d);
			if (d < 6) begin
				t.in_red = (d[0]) ? '1 : '0;
				t.in_green = (d[0]) ? '1 : '0;
				t.in_blue = (d[0]) ? '1 : '0;
				t.in_alpha = (d[0]) ? '1 : '0;
			end
			send_texel(t);
		end
		drain();

		for (int p = 0; p < 12; p++) begin
			mode = p % 4;
			src_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 11 : 52) : 0;
			dst_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 11 : 52) : 0;
			case (p)
				0: begin
					write_reg(CFG_APEX_X, 51'h20000);
					write_reg(CFG_TOP_OFFSET_X, 51'h1FFFF);
					write_reg(CFG_TOP_HEIGHT, 51'h1FFFF);
					write_reg(CFG_TOP_WIDTH, 51'h1FFFF);
					write_reg(CFG_BOTTOM_FRAC, 51'h20000);
					write_reg(CFG_WIDGET_COLOR, '1);
					write_reg(CFG_PEAK_ALPHA, 51'h1FFFF);
				end
				1: begin
					write_reg(CFG_APEX_X, 51'h1FFFF);
					write_reg(CFG_TOP_OFFSET_X, 51'h20000);
					write_reg(CFG_TOP_HEIGHT, 51'h20000);
					write_reg(CFG_TOP_WIDTH, 51'h20000);
					write_reg(CFG_BOTTOM_FRAC, 51'h1FFFF);
					write_reg(CFG_WIDGET_COLOR, '0);
					write_reg(CFG_PEAK_ALPHA, 51'd0);
				end
				2: begin
					write_reg(CFG_TOP_HEIGHT, 51'd0);
					write_reg(CFG_BOTTOM_FRAC, 51'd0);
					write_reg(CFG_APEX_X, 51'd32768);
					write_reg(CFG_TOP_WIDTH, 51'd65536);
					write_reg(CFG_PEAK_ALPHA, 51'd65536);
				end
				3: begin
					write_reg(CFG_TOP_HEIGHT, 51'd65535);
					write_reg(CFG_TOP_WIDTH, 51'h3C000);
					write_reg(CFG_CFG_OOR_IDX(), 51'h5);
				end
				default: begin
					write_reg(CFG_APEX_X, CFG_DATA_W'($urandom_range(65536)));
					write_reg(CFG_TOP_OFFSET_X,
						CFG_DATA_W'($urandom_range(65536) - 32768));
					write_reg(CFG_TOP_HEIGHT, CFG_DATA_W'(($urandom_range(9) == 0)
						? $urandom : $urandom_range(70000)));
					write_reg(CFG_TOP_WIDTH, CFG_DATA_W'(($urandom_range(9) == 0)
						? $urandom : $urandom_range(80000)));
					write_reg(CFG_BOTTOM_FRAC, CFG_DATA_W'(($urandom_range(9) == 0)
						? $urandom : $urandom_range(40000)));
					write_reg(CFG_WIDGET_COLOR, rand_color());
					write_reg(CFG_PEAK_ALPHA, CFG_DATA_W'($urandom_range(131071)));
				end
			endcase
			for (int n = 0; n < 42; n++)
				send_texel(rand_texel());
			drain();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	function automatic logic [CFG_IDX_W-1:0] CFG_CFG_OOR_IDX();
		return 3'd7;
	endfunction
endmodule

/* sim.f */
hw/rtl/trtb_pkg.sv
hw/rtl/trtb_div.sv
hw/rtl/trtb_geom.sv
hw/rtl/trtb_blend.sv
hw/rtl/triangle_ramp_texture_blend_unit.sv
tb/trtb_blend_checker.sv
tb/triangle_ramp_texture_blend_unit_tb.sv
